// ----- src/lzss_window_decompressor_core_assert.svh -----
// assertion macros shared by the checker of the lzss window decompressor
// no dependencies; included by files that assert
`ifndef LZSS_WINDOW_DECOMPRESSOR_CORE_ASSERT_SVH
`define LZSS_WINDOW_DECOMPRESSOR_CORE_ASSERT_SVH

// antecedent in one cycle, consequent in the next, masked while in reset
`define LZWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lzwd assertion failed");

// consequent must hold in the cycle after a reset cycle
`define LZWD_ASSERT_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("lzwd reset assertion failed");

`endif

// ----- src/lzwd_pkg.sv -----
// shared types and constants of the lzss window decompressor
// no dependencies
`timescale 1ns / 1ps

package lzwd_pkg;

    // fixed field widths of the token, result and configuration items
    localparam int DIST_W     = 12;
    localparam int LEN_CODE_W = 6;
    localparam int LIT_W      = 8;
    localparam int OUT_SYM_W  = 8;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = $clog2(DIST_W + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_BIAS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_CAP  = CFG_IDX_W'(1);

    // configuration reset values
    localparam logic [CFG_W-1:0] LEN_BIAS_RST = CFG_W'(3);
    localparam logic [CFG_W-1:0] LEN_CAP_RST  = CFG_W'(18);

    // one input token
    typedef struct packed {
        logic                  is_match;
        logic [LIT_W-1:0]      literal;
        logic [LEN_CODE_W-1:0] length_code;
        logic [DIST_W-1:0]     distance;
    } t_in_item;

    // one decoded symbol
    typedef struct packed {
        logic [OUT_SYM_W-1:0] symbol;
        logic                 last;
    } t_out_item;

    // live configuration seen by the front end
    typedef struct packed {
        logic [CFG_W-1:0] len_bias;
        logic [CFG_W-1:0] len_cap;
    } t_cfg;

endpackage

// ----- src/lzss_window_decompressor_core.sv -----
// top level of the lzss window decompressor: config registers, front end, queues, back end
// depends on lzwd_pkg, lzwd_fifo, lzwd_front, lzwd_back
//
// channel   direction  handshake                 payload
// token     in         push / full               i_token (t_in_item)
// result    out        empty / pop               o_result (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// the back end emits one symbol per cycle while the result queue has room; a literal is
// a token load and one symbol, a match a token load and length symbols from window ram
// the front end runs up to 11 distance reduction steps per match when HIST_DEPTH is
// not a power of two; a 2-entry token queue lets it run ahead
// results go through a 4-entry queue; the back end pauses while that queue has no room
// reset is synchronous; never written window entries read as zero, with no clearing pass
`timescale 1ns / 1ps

module lzss_window_decompressor_core
    import lzwd_pkg::*;
#(
    parameter int HIST_DEPTH   = 4096,
    parameter int SYMBOL_WIDTH = 8,
    parameter int MAX_MATCH    = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_token,
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW       = $clog2(HIST_DEPTH);
    localparam int LEN_W    = $clog2(MAX_MATCH + 1);
    localparam int TOK_W    = 1 + SYMBOL_WIDTH + LEN_W + AW;
    localparam int TQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    t_cfg                        r_cfg;
    logic                        tok_push;
    logic [TOK_W-1:0]            tok_wdata;
    logic                        tok_full;
    logic                        tok_pop;
    logic [TOK_W-1:0]            tok_rdata;
    logic                        tok_empty;
    logic                        out_push;
    t_out_item                   out_item;
    logic [$clog2(OQ_DEPTH+1)-1:0] out_count;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.len_bias <= LEN_BIAS_RST;
            r_cfg.len_cap  <= LEN_CAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LEN_BIAS: r_cfg.len_bias <= i_cfg_data;
                CFG_LEN_CAP:  r_cfg.len_cap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // token intake
    lzwd_front #(
        .HIST_DEPTH   (HIST_DEPTH),
        .SYMBOL_WIDTH (SYMBOL_WIDTH),
        .MAX_MATCH    (MAX_MATCH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_token),
        .i_cfg      (r_cfg),
        .o_tok_push (tok_push),
        .o_tok_data (tok_wdata),
        .i_tok_full (tok_full)
    );

    // queue between front and back
    lzwd_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (TQ_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok_wdata),
        .o_full  (tok_full),
        .i_pop   (tok_pop),
        .o_data  (tok_rdata),
        .o_empty (tok_empty),
        .o_count ()
    );

    // window copy engine
    lzwd_back #(
        .HIST_DEPTH   (HIST_DEPTH),
        .SYMBOL_WIDTH (SYMBOL_WIDTH),
        .MAX_MATCH    (MAX_MATCH),
        .OQ_DEPTH     (OQ_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_empty (tok_empty),
        .o_tok_pop   (tok_pop),
        .i_tok_data  (tok_rdata),
        .o_out_push  (out_push),
        .o_out_item  (out_item),
        .i_out_count (out_count)
    );

    // result queue
    lzwd_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_item),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty),
        .o_count (out_count)
    );

endmodule

// ----- src/lzwd_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies; read during write returns the old contents
`timescale 1ns / 1ps

module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/lzwd_fifo.sv -----
// small register fifo with occupancy count
// no dependencies; used for the token queue and the result queue
`timescale 1ns / 1ps

module lzwd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- src/lzwd_front.sv -----
// front end: accepts tokens, reduces the distance into the window and clamps the length
// depends on lzwd_pkg; feeds the token queue
`timescale 1ns / 1ps

module lzwd_front
    import lzwd_pkg::*;
#(
    parameter int HIST_DEPTH   = 4096,
    parameter int SYMBOL_WIDTH = 8,
    parameter int MAX_MATCH    = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  t_in_item       i_item,
    input  t_cfg           i_cfg,
    output logic           o_tok_push,
    output logic [1+SYMBOL_WIDTH+$clog2(MAX_MATCH+1)+$clog2(HIST_DEPTH)-1:0] o_tok_data,
    input  logic           i_tok_full
);

    localparam int AW      = $clog2(HIST_DEPTH);
    localparam int LEN_W   = $clog2(MAX_MATCH + 1);
    localparam bit IS_POW2 = ((HIST_DEPTH & (HIST_DEPTH - 1)) == 0);

    // number of compare-subtract steps that bring a distance below the window
    function automatic int f_nstep(input int w);
        int n;
        n = 0;
        for (int i = 0; i < DIST_W; i++) begin
            if ((longint'(w) << i) <= longint'((1 << DIST_W) - 1)) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int NSTEP = IS_POW2 ? 0 : f_nstep(HIST_DEPTH);
    localparam logic [STEP_W-1:0] NSTEP_V = STEP_W'(NSTEP);
    localparam logic [DIST_W:0]   WIN_TH  = (DIST_W + 1)'(HIST_DEPTH);
    localparam logic [7:0]        MAX_M8  = 8'(MAX_MATCH);

    typedef struct packed {
        logic                    is_match;
        logic [SYMBOL_WIDTH-1:0] sym;
        logic [LEN_W-1:0]        len;
        logic [AW-1:0]           back_dist;
    } t_token;

    logic              r_valid, n_valid;
    t_in_item          r_item;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [STEP_W-1:0] r_step, n_step;
    logic              done;
    logic              accept;
    logic [STEP_W-1:0] step_idx;
    logic [DIST_W:0]   thr;
    logic [7:0]        max8;
    logic [7:0]        lim8;
    logic [7:0]        len8;
    t_token            tok;

    assign done       = (r_step == '0);
    assign o_tok_push = r_valid && done && !i_tok_full;
    assign o_full     = r_valid && !o_tok_push;
    assign accept     = i_push && !o_full;
    assign step_idx   = r_step - 1'b1;
    assign thr        = WIN_TH << step_idx;

    // holding register and distance reduction, one step per cycle
    always_comb begin
        n_valid = r_valid;
        n_dist  = r_dist;
        n_step  = r_step;
        if (accept) begin
            n_valid = 1'b1;
            n_dist  = i_item.distance;
            n_step  = i_item.is_match ? NSTEP_V : '0;
        end else if (o_tok_push) begin
            n_valid = 1'b0;
        end else if (r_valid && !done) begin
            n_step = step_idx;
            if ({1'b0, r_dist} >= thr) begin
                n_dist = DIST_W'({1'b0, r_dist} - thr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_dist <= n_dist;
    end

    // match length: clamp limit to 1..MAX_MATCH, clamp length, zero becomes one, as does a literal
    always_comb begin
        max8 = {1'b0, i_cfg.len_cap};
        lim8 = (max8 > MAX_M8) ? MAX_M8 : max8;
        if (lim8 == '0) begin
            lim8 = 8'd1;
        end
        len8 = {2'b00, r_item.length_code} + {1'b0, i_cfg.len_bias};
        if (len8 > lim8) begin
            len8 = lim8;
        end
        if (len8 == '0 || !r_item.is_match) begin
            len8 = 8'd1;
        end
    end

    // token to the back end
    always_comb begin
        tok.is_match  = r_item.is_match;
        tok.sym       = SYMBOL_WIDTH'(r_item.literal);
        tok.len       = LEN_W'(len8);
        tok.back_dist = AW'(r_dist);
    end

    assign o_tok_data = tok;

endmodule

// ----- src/lzwd_back.sv -----
// back end: emits literals and window copies, one symbol per cycle while the result queue has room
// depends on lzwd_pkg and lzwd_ram; drains the token queue into the result queue
`timescale 1ns / 1ps

module lzwd_back
    import lzwd_pkg::*;
#(
    parameter int HIST_DEPTH   = 4096,
    parameter int SYMBOL_WIDTH = 8,
    parameter int MAX_MATCH    = 64,
    parameter int OQ_DEPTH     = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_tok_empty,
    output logic o_tok_pop,
    input  logic [1+SYMBOL_WIDTH+$clog2(MAX_MATCH+1)+$clog2(HIST_DEPTH)-1:0] i_tok_data,
    output logic o_out_push,
    output t_out_item o_out_item,
    input  logic [$clog2(OQ_DEPTH+1)-1:0] i_out_count
);

    localparam int AW    = $clog2(HIST_DEPTH);
    localparam int LEN_W = $clog2(MAX_MATCH + 1);
    localparam int CNT_W = $clog2(OQ_DEPTH + 1);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(HIST_DEPTH - 1);
    localparam logic [AW:0]    WIN_SIZE  = (AW + 1)'(HIST_DEPTH);
    localparam logic [CNT_W:0] OQ_LIMIT  = (CNT_W + 1)'(OQ_DEPTH);

    typedef struct packed {
        logic                    is_match;
        logic [SYMBOL_WIDTH-1:0] sym;
        logic [LEN_W-1:0]        len;
        logic [AW-1:0]           back_dist;
    } t_token;

    function automatic logic [AW-1:0] f_next_addr(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    t_token tok;

    // issue side: current token and write position as seen at issue
    logic                    r_busy, n_busy;
    logic                    r_is_match;
    logic [SYMBOL_WIDTH-1:0] r_sym;
    logic [LEN_W-1:0]        r_rem, n_rem;
    logic [AW-1:0]           r_rd, n_rd;
    logic [AW-1:0]           r_iwp, n_iwp;
    logic                    r_iwrap, n_iwrap;

    // write side: symbol whose window data arrives this cycle
    logic                    r_s1_valid;
    logic                    r_s1_last;
    logic                    r_s1_lit;
    logic [SYMBOL_WIDTH-1:0] r_s1_litsym;
    logic [AW-1:0]           r_s1_waddr;
    logic                    r_s1_fill;
    logic                    r_s1_byp;
    logic [SYMBOL_WIDTH-1:0] r_wsym;

    logic                    load;
    logic                    issue;
    logic                    space;
    logic [AW:0]             diff;
    logic [AW-1:0]           src;
    logic [SYMBOL_WIDTH-1:0] ram_q;
    logic [SYMBOL_WIDTH-1:0] s1_sym;

    assign tok       = t_token'(i_tok_data);
    assign load      = !r_busy && !i_tok_empty;
    assign o_tok_pop = load;
    assign space     = ({1'b0, i_out_count} + (CNT_W + 1)'(r_s1_valid)) < OQ_LIMIT;
    assign issue     = r_busy && space;

    // copy source: write position minus distance, around the window
    always_comb begin
        diff = {1'b0, r_iwp} - {1'b0, tok.back_dist};
        if (diff[AW]) begin
            diff = diff + WIN_SIZE;
        end
        src = diff[AW-1:0];
    end

    // token load and symbol issue
    always_comb begin
        n_busy  = r_busy;
        n_rem   = r_rem;
        n_rd    = r_rd;
        n_iwp   = r_iwp;
        n_iwrap = r_iwrap;
        if (load) begin
            n_busy = 1'b1;
            n_rem  = tok.len;
            n_rd   = src;
        end else if (issue) begin
            n_rem   = r_rem - 1'b1;
            n_rd    = f_next_addr(r_rd);
            n_iwp   = f_next_addr(r_iwp);
            n_iwrap = r_iwrap || (r_iwp == LAST_ADDR);
            if (r_rem == LEN_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_iwp      <= '0;
            r_iwrap    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_iwp      <= n_iwp;
            r_iwrap    <= n_iwrap;
            r_s1_valid <= issue;
        end
    end

    // payload of the current token and of the write stage
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_rd  <= n_rd;
        if (load) begin
            r_is_match <= tok.is_match;
            r_sym      <= tok.sym;
        end
        if (issue) begin
            r_s1_last   <= (r_rem == LEN_W'(1));
            r_s1_lit    <= !r_is_match;
            r_s1_litsym <= r_sym;
            r_s1_waddr  <= r_iwp;
            // entries not yet written since reset read as zero
            r_s1_fill   <= r_iwrap || (r_rd < r_iwp);
            // source is the entry being written this very cycle
            r_s1_byp    <= r_s1_valid && (r_s1_waddr == r_rd);
        end
        if (r_s1_valid) begin
            r_wsym <= s1_sym;
        end
    end

    // history window
    lzwd_ram #(
        .WIDTH (SYMBOL_WIDTH),
        .DEPTH (HIST_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_waddr),
        .i_wdata (s1_sym),
        .i_re    (issue && r_is_match),
        .i_raddr (r_rd),
        .o_rdata (ram_q)
    );

    // symbol select: literal, forwarded write, window data or zero for a never written entry
    always_comb begin
        if (r_s1_lit) begin
            s1_sym = r_s1_litsym;
        end else if (r_s1_byp) begin
            s1_sym = r_wsym;
        end else if (r_s1_fill) begin
            s1_sym = ram_q;
        end else begin
            s1_sym = '0;
        end
    end

    assign o_out_push        = r_s1_valid;
    assign o_out_item.symbol = OUT_SYM_W'(s1_sym);
    assign o_out_item.last   = r_s1_last;

endmodule

// ----- src/lzwd_checker.sv -----
// port-level checker of the lzss window decompressor, bound to the top level
// depends on lzwd_pkg and lzss_window_decompressor_core_assert.svh
`timescale 1ns / 1ps
`include "lzss_window_decompressor_core_assert.svh"

module lzwd_checker
    import lzwd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    // reset leaves no result waiting and the intake open
    `LZWD_ASSERT_RESET(a_rst_empty, i_clk, i_rst_n, empty)
    `LZWD_ASSERT_RESET(a_rst_open, i_clk, i_rst_n, !full)

    // a waiting result is not withdrawn and does not change until taken
    `LZWD_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, !empty && !pop, !empty)
    `LZWD_ASSERT_NEXT(a_hold_item, i_clk, i_rst_n, !empty && !pop, $stable(o_result))

endmodule

bind lzss_window_decompressor_core lzwd_checker u_lzwd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
